// ===== sv/ldm_pkg.sv =====
// ----------------------------------------------------------------------------
// Lens distortion map package
// Shared types, constants and fixed-point helpers (Q8.24 working format).
// ----------------------------------------------------------------------------
package ldm_pkg;

  typedef logic signed [31:0] w_t;

  localparam int DIV_BITS  = 32;
  localparam int DIV_LAT   = DIV_BITS + 2;
  localparam int TERMS_LAT = 5;

  localparam w_t W_MAX = 32'sh7fffffff;
  localparam w_t W_MIN = 32'sh80000000;
  localparam w_t W_ONE = 32'sh01000000;
  localparam logic signed [63:0] W_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN64 = -64'sd2147483648;
  localparam logic signed [41:0] OUT_MAX42 = 42'sd8388607;
  localparam logic signed [41:0] OUT_MIN42 = -42'sd8388608;

  localparam logic [7:0] REG_FOCAL_X = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;
  localparam logic [7:0] REG_RADIAL_K1 = 8'd4;
  localparam logic [7:0] REG_RADIAL_K2 = 8'd5;
  localparam logic [7:0] REG_TANG_P1 = 8'd6;
  localparam logic [7:0] REG_TANG_P2 = 8'd7;

  typedef struct packed {
    logic              kind;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic valid;
    logic kind;
    w_t   xc;
    w_t   yc;
    w_t   x;
    w_t   y;
    logic sat;
  } item_t;

  typedef struct packed {
    w_t k1;
    w_t k2;
    w_t p1;
    w_t p2;
  } coef_t;

  typedef struct packed {
    logic sat;
    w_t   v;
  } wres_t;

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] rem;
    logic [31:0] lq;
    logic        neg;
    logic        spec;
    wres_t       spec_res;
  } div_lane_t;

  // saturate a wide signed value to the working format
  function automatic wres_t sat_w(input logic signed [63:0] v);
    wres_t r;
    if (v > W_MAX64) begin
      r = {1'b1, W_MAX};
    end else if (v < W_MIN64) begin
      r = {1'b1, W_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // drop 24 fraction bits, round to nearest with ties up
  function automatic logic signed [40:0] round24(input logic signed [63:0] p);
    logic signed [64:0] v;
    v = 65'(p) + 65'sd8388608;
    return 41'(v >>> 24);
  endfunction

  function automatic wres_t mul_w(input w_t a, input w_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat_w(64'(round24(p)));
  endfunction

  // prepare one quotient lane: numerator scaled by 2^24 plus half divisor
  // a negative magnitude too large rests at W_MIN without flagging
  function automatic div_lane_t div_init(input logic signed [32:0] n,
                                         input w_t d);
    div_lane_t   s;
    logic [32:0] mag;
    logic [57:0] x;
    logic [63:0] lim;
    s.neg = n[32];
    mag = s.neg ? 33'(-n) : 33'(n);
    x = (58'(mag) << 24) + 58'(d[31:1]);
    lim = {d, 32'b0};
    s.d = d;
    s.rem = 32'(x[57:32]);
    s.lq = x[31:0];
    s.spec = 1'b0;
    s.spec_res = '0;
    if (d <= 0) begin
      s.spec = 1'b1;
      s.spec_res.sat = 1'b1;
      if (n > 0) begin
        s.spec_res.v = W_MAX;
      end else if (n < 0) begin
        s.spec_res.v = W_MIN;
      end else begin
        s.spec_res.v = '0;
      end
    end else if (64'(x) >= lim) begin
      s.spec = 1'b1;
      s.spec_res.sat = ~s.neg;
      s.spec_res.v = s.neg ? W_MIN : W_MAX;
    end
    return s;
  endfunction

  // one restoring step: one quotient bit
  function automatic div_lane_t div_step(input div_lane_t s);
    div_lane_t   r;
    logic [32:0] t;
    logic        qb;
    r = s;
    t = {s.rem, s.lq[31]};
    if (t >= {1'b0, s.d}) begin
      r.rem = 32'(t - {1'b0, s.d});
      qb = 1'b1;
    end else begin
      r.rem = t[31:0];
      qb = 1'b0;
    end
    r.lq = {s.lq[30:0], qb};
    return r;
  endfunction

  function automatic wres_t div_done(input div_lane_t s);
    wres_t r;
    if (s.spec) begin
      r = s.spec_res;
    end else if (s.neg) begin
      if (s.lq > 32'h80000000) begin
        r = {1'b0, W_MIN};
      end else begin
        r = {1'b0, 32'(-{1'b0, s.lq})};
      end
    end else if (s.lq > 32'h7fffffff) begin
      r = {1'b1, W_MAX};
    end else begin
      r = {1'b0, s.lq};
    end
    return r;
  endfunction

endpackage

// ===== sv/ldm_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider pair
// Two rounded n*2^24/d quotients, one bit per stage, item carried alongside.
// ----------------------------------------------------------------------------
module ldm_div import ldm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             in_item,
  input  logic signed [32:0] num_x,
  input  logic signed [32:0] num_y,
  input  w_t                den_x,
  input  w_t                den_y,
  output item_t             out_item,
  output w_t                quo_x,
  output w_t                quo_y,
  output logic              quo_sat
);

  item_t     st_item [DIV_BITS+1];
  div_lane_t lane_x [DIV_BITS+1];
  div_lane_t lane_y [DIV_BITS+1];
  wres_t     res_x;
  wres_t     res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_item[0] <= '0;
    end else begin
      st_item[0] <= in_item;
    end
    lane_x[0] <= div_init(num_x, den_x);
    lane_y[0] <= div_init(num_y, den_y);
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        st_item[g+1] <= '0;
      end else begin
        st_item[g+1] <= st_item[g];
      end
      lane_x[g+1] <= div_step(lane_x[g]);
      lane_y[g+1] <= div_step(lane_y[g]);
    end
  end

  assign res_x = div_done(lane_x[DIV_BITS]);
  assign res_y = div_done(lane_y[DIV_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item <= '0;
    end else begin
      out_item <= st_item[DIV_BITS];
    end
    quo_x <= res_x.v;
    quo_y <= res_y.v;
    quo_sat <= res_x.sat | res_y.sat;
  end

endmodule

// ===== sv/ldm_terms.sv =====
// ----------------------------------------------------------------------------
// Distortion terms pipeline
// Radial factor and tangential offsets of the point in item.x, item.y.
// ----------------------------------------------------------------------------
module ldm_terms import ldm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t in_item,
  input  coef_t coef,
  output item_t out_item,
  output w_t    factor,
  output w_t    dx,
  output w_t    dy,
  output logic  tsat
);

  item_t it1, it2, it3, it4;
  w_t    xx, yy, xy, sat1_unused;
  logic  sat1, sat2, sat3, sat4;
  w_t    rr, txy, xx2, yy2;
  w_t    rr2, a1, tx, ty, a5, a6;
  w_t    a2, b1, b2, a1_4, a5_4, a6_4;
  wres_t m_xx, m_yy, m_xy;
  wres_t s_rr, s_txy;
  wres_t m_rr2, m_a1, s_tx, s_ty, m_a5, m_a6;
  wres_t m_a2, m_b1, m_b2;
  wres_t s_fac, s_dx, s_dy;

  assign sat1_unused = '0;

  always_comb begin
    m_xx = mul_w(in_item.x, in_item.x);
    m_yy = mul_w(in_item.y, in_item.y);
    m_xy = mul_w(in_item.x, in_item.y);
    s_rr = sat_w(64'(xx) + 64'(yy));
    s_txy = sat_w(64'(xy) + 64'(xy));
    m_rr2 = mul_w(rr, rr);
    m_a1 = mul_w(coef.k1, rr);
    s_tx = sat_w(64'(rr) + 64'(xx2) + 64'(xx2));
    s_ty = sat_w(64'(rr) + 64'(yy2) + 64'(yy2));
    m_a5 = mul_w(coef.p2, txy);
    m_a6 = mul_w(coef.p1, txy);
    m_a2 = mul_w(coef.k2, rr2);
    m_b1 = mul_w(coef.p2, tx);
    m_b2 = mul_w(coef.p1, ty);
    s_fac = sat_w(64'(W_ONE) + 64'(a1_4) + 64'(a2));
    s_dx = sat_w(64'(a6_4) + 64'(b1));
    s_dy = sat_w(64'(b2) + 64'(a5_4));
  end

  always_ff @(posedge clk) begin
    xx <= m_xx.v;
    yy <= m_yy.v;
    xy <= m_xy.v | sat1_unused;
    sat1 <= m_xx.sat | m_yy.sat | m_xy.sat;

    rr <= s_rr.v;
    txy <= s_txy.v;
    xx2 <= xx;
    yy2 <= yy;
    sat2 <= sat1 | s_rr.sat | s_txy.sat;

    rr2 <= m_rr2.v;
    a1 <= m_a1.v;
    tx <= s_tx.v;
    ty <= s_ty.v;
    a5 <= m_a5.v;
    a6 <= m_a6.v;
    sat3 <= sat2 | m_rr2.sat | m_a1.sat | s_tx.sat | s_ty.sat | m_a5.sat | m_a6.sat;

    a2 <= m_a2.v;
    b1 <= m_b1.v;
    b2 <= m_b2.v;
    a1_4 <= a1;
    a5_4 <= a5;
    a6_4 <= a6;
    sat4 <= sat3 | m_a2.sat | m_b1.sat | m_b2.sat;

    factor <= s_fac.v;
    dx <= s_dx.v;
    dy <= s_dy.v;
    tsat <= sat4 | s_fac.sat | s_dx.sat | s_dy.sat;

    if (rst) begin
      it1 <= '0;
      it2 <= '0;
      it3 <= '0;
      it4 <= '0;
      out_item <= '0;
    end else begin
      it1 <= in_item;
      it2 <= it1;
      it3 <= it2;
      it4 <= it3;
      out_item <= it4;
    end
  end

endmodule

// ===== sv/ldm_cell.sv =====
// ----------------------------------------------------------------------------
// Undistortion cell
// One refinement step x = (xc - dx) / factor; other kinds pass unchanged.
// ----------------------------------------------------------------------------
module ldm_cell import ldm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t in_item,
  input  coef_t coef,
  output item_t out_item
);

  item_t t_item, n_item, d_item, n_item_next;
  w_t    t_fac, t_dx, t_dy;
  logic  t_sat;
  wres_t s_nx, s_ny;
  w_t    num_x, num_y, fac;
  w_t    q_x, q_y;
  logic  q_sat;

  ldm_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .coef     (coef),
    .out_item (t_item),
    .factor   (t_fac),
    .dx       (t_dx),
    .dy       (t_dy),
    .tsat     (t_sat)
  );

  assign s_nx = sat_w(64'(t_item.xc) - 64'(t_dx));
  assign s_ny = sat_w(64'(t_item.yc) - 64'(t_dy));

  always_comb begin
    n_item_next = t_item;
    n_item_next.sat = t_item.sat | (t_item.kind & (t_sat | s_nx.sat | s_ny.sat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_item <= '0;
    end else begin
      n_item <= n_item_next;
    end
    num_x <= s_nx.v;
    num_y <= s_ny.v;
    fac <= t_fac;
  end

  ldm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_item  (n_item),
    .num_x    (33'(num_x)),
    .num_y    (33'(num_y)),
    .den_x    (fac),
    .den_y    (fac),
    .out_item (d_item),
    .quo_x    (q_x),
    .quo_y    (q_y),
    .quo_sat  (q_sat)
  );

  always_comb begin
    out_item = d_item;
    if (d_item.kind) begin
      out_item.x = q_x;
      out_item.y = q_y;
      out_item.sat = d_item.sat | q_sat;
    end
  end

endmodule

// ===== sv/lens_distortion_map.sv =====
// ----------------------------------------------------------------------------
// Lens distortion map
// Brown-Conrady mapping of pixel coordinates, two radial and two tangential
// terms, applied (kind 0) or removed by fixed-step inversion (kind 1).
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a pixel; the pixel is taken at any edge where busy is
//   low, so a new coordinate may be given every clock. busy is a registered
//   copy of rst, so it is high after each clock edge that samples reset.
//   Each transfer yields one result on the result port, marked by done for
//   exactly one cycle. Results leave in input order. The pipeline is built
//   from pipelined dividers (34 stages, one quotient bit per restoring step)
//   and five-stage terms pipelines, in the front end and in every cell of the
//   chain; the chain has ITERATIONS cells, ten steps at the default.
//   The receiver cannot hold a result off; none is needed, as there is no
//   back-pressure inside the pipeline.
//   Write registers with wr_en, wr_index and wr_data only while no pixel is
//   in flight; indexes above seven are dropped.
//   Reset restores the default camera registers and flushes every item in
//   flight; no done strobe appears for pixels taken before reset.
// ----------------------------------------------------------------------------
module lens_distortion_map import ldm_pkg::*; #(
  parameter int ITERATIONS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [23:0] wr_data,
  output logic        done,
  output result_t     result
);

  localparam int LATENCY = 3 + DIV_LAT + TERMS_LAT
                           + ITERATIONS * (TERMS_LAT + 1 + DIV_LAT);

  // configuration registers
  logic [23:0]        focal_x, focal_y;
  logic signed [23:0] center_x, center_y;
  logic signed [23:0] radial_k1, radial_k2, tang_p1, tang_p2;
  coef_t              coef;

  logic   acc;
  logic   p_valid;
  pixel_t p_reg;
  item_t  p_item, n_item, d_item, e_item;
  w_t     qx, qy;
  logic   qsat;
  w_t     t_fac, t_dx, t_dy;
  logic   t_sat;
  wres_t  r_x, r_y;
  item_t  chain [ITERATIONS+1];
  item_t  chain0_next;
  item_t  last;
  logic signed [40:0] pix_x, pix_y;
  logic signed [41:0] sum_x, sum_y;
  result_t result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 24'd148480;
      focal_y <= 24'd148480;
      center_x <= 24'sd81920;
      center_y <= 24'sd61440;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tang_p1 <= '0;
      tang_p2 <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FOCAL_X: focal_x <= wr_data;
        REG_FOCAL_Y: focal_y <= wr_data;
        REG_CENTER_X: center_x <= wr_data;
        REG_CENTER_Y: center_y <= wr_data;
        REG_RADIAL_K1: radial_k1 <= wr_data;
        REG_RADIAL_K2: radial_k2 <= wr_data;
        REG_TANG_P1: tang_p1 <= wr_data;
        REG_TANG_P2: tang_p2 <= wr_data;
        default: ;
      endcase
    end
  end

  // coefficients move from Q4.20 into the Q8.24 working format
  assign coef.k1 = {{4{radial_k1[23]}}, radial_k1, 4'b0};
  assign coef.k2 = {{4{radial_k2[23]}}, radial_k2, 4'b0};
  assign coef.p1 = {{4{tang_p1[23]}}, tang_p1, 4'b0};
  assign coef.p2 = {{4{tang_p2[23]}}, tang_p2, 4'b0};

  // busy is a registered copy of reset, high after each edge that samples it
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign acc = start & ~busy;

  // register the transfer
  always_ff @(posedge clk) begin
    p_reg <= pixel;
    p_valid <= acc & ~rst;
  end

  always_comb begin
    p_item = '0;
    p_item.valid = p_valid;
    p_item.kind = p_reg.kind;
  end

  // normalise by the principal point and the focal lengths
  ldm_div u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_item  (p_item),
    .num_x    (33'(p_reg.point_x) - 33'(center_x)),
    .num_y    (33'(p_reg.point_y) - 33'(center_y)),
    .den_x    (w_t'({8'b0, focal_x})),
    .den_y    (w_t'({8'b0, focal_y})),
    .out_item (d_item),
    .quo_x    (qx),
    .quo_y    (qy),
    .quo_sat  (qsat)
  );

  always_comb begin
    n_item = d_item;
    n_item.xc = qx;
    n_item.yc = qy;
    n_item.x = qx;
    n_item.y = qy;
    n_item.sat = qsat;
  end

  // forward model; used by kind 0 only
  ldm_terms u_fwd (
    .clk      (clk),
    .rst      (rst),
    .in_item  (n_item),
    .coef     (coef),
    .out_item (e_item),
    .factor   (t_fac),
    .dx       (t_dx),
    .dy       (t_dy),
    .tsat     (t_sat)
  );

  assign r_x = sat_w(64'(round24(64'(t_fac) * 64'(e_item.xc))) + 64'(t_dx));
  assign r_y = sat_w(64'(round24(64'(t_fac) * 64'(e_item.yc))) + 64'(t_dy));

  always_comb begin
    chain0_next = e_item;
    if (!e_item.kind) begin
      chain0_next.x = r_x.v;
      chain0_next.y = r_y.v;
      chain0_next.sat = e_item.sat | t_sat | r_x.sat | r_y.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= chain0_next;
    end
  end

  // inversion: one cell per refinement step
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ldm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_item  (chain[g]),
      .coef     (coef),
      .out_item (chain[g+1])
    );
  end

  assign last = chain[ITERATIONS];

  // back to pixels: focal * v rounded, plus centre, saturated to 24 bits
  assign pix_x = round24(64'(signed'({1'b0, focal_x})) * 64'(last.x));
  assign pix_y = round24(64'(signed'({1'b0, focal_y})) * 64'(last.y));
  assign sum_x = 42'(pix_x) + 42'(center_x);
  assign sum_y = 42'(pix_y) + 42'(center_y);

  always_comb begin
    result_next.saturated = last.sat;
    if (sum_x > OUT_MAX42) begin
      result_next.out_x = 24'sh7fffff;
      result_next.saturated = 1'b1;
    end else if (sum_x < OUT_MIN42) begin
      result_next.out_x = 24'sh800000;
      result_next.saturated = 1'b1;
    end else begin
      result_next.out_x = sum_x[23:0];
    end
    if (sum_y > OUT_MAX42) begin
      result_next.out_y = 24'sh7fffff;
      result_next.saturated = 1'b1;
    end else if (sum_y < OUT_MIN42) begin
      result_next.out_y = 24'sh800000;
      result_next.saturated = 1'b1;
    end else begin
      result_next.out_y = sum_y[23:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= last.valid & ~rst;
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LATENCY done)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(acc, LATENCY))
    else $error("result without matching transfer");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");
`endif

endmodule
